// ----- src/cosine_similarity_score_unit_assert.svh -----
// Assertion macros used by the checker of the score unit.
`ifndef COSINE_SIMILARITY_SCORE_UNIT_ASSERT_SVH
`define COSINE_SIMILARITY_SCORE_UNIT_ASSERT_SVH

// Implication checked in the same cycle.
`define CSSU_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed: label");

// Implication checked in the next cycle.
`define CSSU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed: label");

`endif

// ----- src/cssu_pkg.sv -----
// Types and constants of the cosine similarity score unit.
`default_nettype none
package cssu_pkg;
	localparam int unsigned COUNT_W = 16;
	localparam int unsigned SQ_W    = 42;
	localparam int unsigned TOT_W   = 26;
	localparam int unsigned SCORE_W = 15;
	localparam int unsigned PROD_W  = 2 * SQ_W;
	localparam int unsigned NUM_W   = SQ_W + SCORE_W;
	localparam logic [SCORE_W-1:0] SCORE_FULL = 15'd25600;

	typedef struct packed {
		logic [COUNT_W-1:0] query_count;
		logic [COUNT_W-1:0] doc_count;
		logic               last_term;
	} item_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score_q8;
		logic               zero_norm;
	} result_t;

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_ACC  = 7'b0000010,
		ST_MUL  = 7'b0000100,
		ST_SQRT = 7'b0001000,
		ST_DCHK = 7'b0010000,
		ST_DIV  = 7'b0100000,
		ST_RMUL = 7'b1000000
	} state_t;
endpackage
`default_nettype wire

// ----- src/cosine_similarity_score_unit.sv -----
// Top level of the cosine similarity score unit.
// A term without the last flag leaves busy low; a new term is accepted every cycle while busy is low.
// A last term keeps busy high through the 42-step shift-add multiplier, the 42-step square
// root and the 15-step shared divider, which runs a second time when length scaling applies;
// a saturating quotient skips the first division and a zero norm ends in the multiplier state.
// The result strobe is high in the first cycle after busy falls. Reset clears the
// accumulators, the sequencer and the length scaling enable.
`default_nettype none
module cosine_similarity_score_unit (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               start,
	output logic              busy,
	input  cssu_pkg::item_t   item,
	output logic              done,
	output cssu_pkg::result_t result,
	input  wire               cfg_we,
	input  wire               cfg_wdata
);
	localparam int unsigned SQ_W  = cssu_pkg::SQ_W;
	localparam int unsigned TOT_W = cssu_pkg::TOT_W;
	localparam int unsigned SC_W  = cssu_pkg::SCORE_W;
	localparam int unsigned P_W   = cssu_pkg::PROD_W;
	localparam int unsigned N_W   = cssu_pkg::NUM_W;
	localparam int unsigned CW    = cssu_pkg::COUNT_W;

	cssu_pkg::state_t state_q;

	logic               en_q;
	logic               vld_s1;
	logic [2*CW-1:0]    pqd_s1, pqq_s1, pdd_s1;
	logic [CW-1:0]      q_s1, d_s1;
	logic [SQ_W-1:0]    dot_q, qq_q, dd_q;
	logic [TOT_W-1:0]   qt_q, dt_q;
	logic [P_W-1:0]     p_q;
	logic [SQ_W+2:0]    rem_q;
	logic [SQ_W-1:0]    root_q;
	logic [N_W-1:0]     num_q;
	logic [SQ_W-1:0]    rr_q, div_q;
	logic [SC_W-1:0]    score_q;
	logic               zero_q, ratio_q, fin_q;
	logic [5:0]         cnt_q;

	logic               accept;
	logic [SQ_W+2:0]    rem_n, trial;
	logic [SQ_W:0]      r2;
	logic               ge;
	logic [N_W-1:0]     n_full;
	logic               ratio_cond;
	logic [SC_W-1:0]    score_c;
	logic [SC_W+TOT_W-1:0] rprod;

	assign accept     = start && !busy;
	assign busy       = (state_q != cssu_pkg::ST_IDLE) || fin_q;
	assign rem_n      = {rem_q[SQ_W:0], p_q[P_W-1 -: 2]};
	assign trial      = {1'b0, root_q, 2'b01};
	assign r2         = {rr_q, num_q[SC_W-1]};
	assign ge         = r2 >= {1'b0, div_q};
	assign n_full     = ({{SC_W{1'b0}}, dot_q} << 14) + ({{SC_W{1'b0}}, dot_q} << 13)
	                  + ({{SC_W{1'b0}}, dot_q} << 10);
	assign ratio_cond = en_q && (dt_q != '0) && (dt_q > qt_q);
	assign score_c    = (score_q > cssu_pkg::SCORE_FULL) ? cssu_pkg::SCORE_FULL : score_q;
	assign rprod      = score_c * qt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q <= 1'b0;
		end else if (cfg_we) begin
			en_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		pqd_s1 <= item.query_count * item.doc_count;
		pqq_s1 <= item.query_count * item.query_count;
		pdd_s1 <= item.doc_count * item.doc_count;
		q_s1   <= item.query_count;
		d_s1   <= item.doc_count;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			state_q <= cssu_pkg::ST_IDLE;
			dot_q   <= '0;
			qq_q    <= '0;
			dd_q    <= '0;
			qt_q    <= '0;
			dt_q    <= '0;
			done    <= 1'b0;
			fin_q   <= 1'b0;
		end else begin
			vld_s1  <= accept;
			done    <= fin_q;
			fin_q   <= 1'b0;
			if (vld_s1) begin
				dot_q <= dot_q + {{(SQ_W-2*CW){1'b0}}, pqd_s1};
				qq_q  <= qq_q + {{(SQ_W-2*CW){1'b0}}, pqq_s1};
				dd_q  <= dd_q + {{(SQ_W-2*CW){1'b0}}, pdd_s1};
				qt_q  <= qt_q + {{(TOT_W-CW){1'b0}}, q_s1};
				dt_q  <= dt_q + {{(TOT_W-CW){1'b0}}, d_s1};
			end
			unique case (state_q)
				cssu_pkg::ST_IDLE: begin
					if (accept && item.last_term) begin
						state_q <= cssu_pkg::ST_ACC;
					end
				end
				cssu_pkg::ST_ACC: begin
					state_q <= cssu_pkg::ST_MUL;
				end
				cssu_pkg::ST_MUL: begin
					if (qq_q == '0 || dd_q == '0) begin
						state_q <= cssu_pkg::ST_IDLE;
						fin_q   <= 1'b1;
					end else if (cnt_q == '0) begin
						state_q <= cssu_pkg::ST_SQRT;
					end
				end
				cssu_pkg::ST_SQRT: begin
					if (cnt_q == '0) begin
						state_q <= cssu_pkg::ST_DCHK;
					end
				end
				cssu_pkg::ST_DCHK: begin
					if (n_full >= {root_q, {SC_W{1'b0}}}) begin
						if (ratio_cond) begin
							state_q <= cssu_pkg::ST_RMUL;
						end else begin
							state_q <= cssu_pkg::ST_IDLE;
							fin_q   <= 1'b1;
						end
					end else begin
						state_q <= cssu_pkg::ST_DIV;
					end
				end
				cssu_pkg::ST_DIV: begin
					if (cnt_q == '0) begin
						if (ratio_cond && !ratio_q) begin
							state_q <= cssu_pkg::ST_RMUL;
						end else begin
							state_q <= cssu_pkg::ST_IDLE;
							fin_q   <= 1'b1;
						end
					end
				end
				cssu_pkg::ST_RMUL: begin
					state_q <= cssu_pkg::ST_DIV;
				end
				default: begin
					state_q <= cssu_pkg::ST_IDLE;
				end
			endcase
			if (fin_q) begin
				dot_q <= '0;
				qq_q  <= '0;
				dd_q  <= '0;
				qt_q  <= '0;
				dt_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fin_q) begin
			result.score_q8  <= zero_q ? '0 : score_c;
			result.zero_norm <= zero_q;
		end
		unique case (state_q)
			cssu_pkg::ST_IDLE: begin
				cnt_q <= 6'(SQ_W - 1);
			end
			cssu_pkg::ST_ACC: begin
				p_q     <= '0;
				cnt_q   <= 6'(SQ_W - 1);
				zero_q  <= 1'b0;
				ratio_q <= 1'b0;
			end
			cssu_pkg::ST_MUL: begin
				p_q    <= {p_q[P_W-2:0], 1'b0} + (dd_q[cnt_q] ? {{SQ_W{1'b0}}, qq_q} : '0);
				cnt_q  <= cnt_q - 6'd1;
				rem_q  <= '0;
				root_q <= '0;
				zero_q <= (qq_q == '0) || (dd_q == '0);
				if (cnt_q == '0) begin
					cnt_q <= 6'(SQ_W - 1);
				end
			end
			cssu_pkg::ST_SQRT: begin
				p_q   <= {p_q[P_W-3:0], 2'b00};
				cnt_q <= cnt_q - 6'd1;
				if (rem_n >= trial) begin
					rem_q  <= rem_n - trial;
					root_q <= {root_q[SQ_W-2:0], 1'b1};
				end else begin
					rem_q  <= rem_n;
					root_q <= {root_q[SQ_W-2:0], 1'b0};
				end
			end
			cssu_pkg::ST_DCHK: begin
				num_q   <= n_full;
				rr_q    <= n_full[N_W-1:SC_W];
				div_q   <= root_q;
				cnt_q   <= 6'(SC_W - 1);
				score_q <= (n_full >= {root_q, {SC_W{1'b0}}}) ? cssu_pkg::SCORE_FULL : '0;
			end
			cssu_pkg::ST_DIV: begin
				num_q   <= {num_q[N_W-2:0], 1'b0};
				score_q <= {score_q[SC_W-2:0], ge};
				rr_q    <= ge ? SQ_W'(r2 - {1'b0, div_q}) : r2[SQ_W-1:0];
				cnt_q   <= cnt_q - 6'd1;
			end
			cssu_pkg::ST_RMUL: begin
				num_q   <= {{(N_W-SC_W-TOT_W){1'b0}}, rprod};
				rr_q    <= {{(SQ_W-TOT_W){1'b0}}, rprod[SC_W+TOT_W-1:SC_W]};
				div_q   <= {{(SQ_W-TOT_W){1'b0}}, dt_q};
				score_q <= '0;
				ratio_q <= 1'b1;
				cnt_q   <= 6'(SC_W - 1);
			end
			default: begin
				cnt_q <= cnt_q;
			end
		endcase
	end
endmodule
`default_nettype wire

// ----- src/cssu_checker.sv -----
// Port-level checker for the score unit and its bind.
`default_nettype none
`include "cosine_similarity_score_unit_assert.svh"
module cssu_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               start,
	input wire               busy,
	input cssu_pkg::item_t   item,
	input wire               done,
	input cssu_pkg::result_t result
);
	`CSSU_ASSERT_NEXT(a_last_sets_busy, clk, arst_n, start && !busy && item.last_term, busy)
	`CSSU_ASSERT_NEXT(a_single_strobe, clk, arst_n, done, !done)
	`CSSU_ASSERT_NOW(a_zero_score, clk, arst_n, done && result.zero_norm, result.score_q8 == '0)
	`CSSU_ASSERT_NOW(a_score_range, clk, arst_n, done, result.score_q8 <= cssu_pkg::SCORE_FULL)
	`CSSU_ASSERT_NEXT(a_plain_no_busy, clk, arst_n, !busy && !(start && item.last_term), !done)
endmodule

bind cosine_similarity_score_unit cssu_checker u_cssu_checker (.*);
`default_nettype wire
